@@ sv/sbd_pkg.sv @@
// ----------------------------------------------------------------------------
// sbd_pkg
// types, constants and the arctangent table shared by the bearing/distance
// pipeline
// ----------------------------------------------------------------------------
package sbd_pkg;

   localparam int CHANNELS     = 16;
   localparam int CORDIC_STEPS = 20;
   localparam int PRESCALE     = 14;
   localparam int DIST_BITS    = 8;
   localparam int QUARTER_Q16  = 90 * 65536;
   localparam int STEP_W       = $clog2(CORDIC_STEPS + 1);

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_POS  = 2'd1,
      ACT_STOP = 2'd2
   } action_type;

   typedef struct packed {
      logic [3:0]         channel;
      logic               slot_active;
      logic               spatial_enabled;
      logic               playing;
      logic signed [15:0] source_x;
      logic signed [15:0] source_y;
      logic signed [15:0] listener_x;
      logic signed [15:0] listener_y;
   } req_word_type;

   typedef struct packed {
      logic [3:0] out_channel;
      action_type action;
      logic [8:0] bearing_deg;
      logic [7:0] scaled_distance;
   } rsp_word_type;

   typedef struct packed {
      logic [3:0]         channel;
      action_type         action;
      logic [8:0]         base;
      logic               use_cordic;
      logic signed [32:0] x;
      logic signed [32:0] y;
      logic signed [24:0] z;
      logic [49:0]        target;
      logic [7:0]         d;
      logic [15:0]        d2;
   } cell_type;

   function automatic logic [21:0] atan_deg(input logic [STEP_W-1:0] step);
      logic [21:0] r;
      case (step)
         5'd0:    r = 22'd2949120;
         5'd1:    r = 22'd1740967;
         5'd2:    r = 22'd919879;
         5'd3:    r = 22'd466945;
         5'd4:    r = 22'd234379;
         5'd5:    r = 22'd117304;
         5'd6:    r = 22'd58666;
         5'd7:    r = 22'd29335;
         5'd8:    r = 22'd14668;
         5'd9:    r = 22'd7334;
         5'd10:   r = 22'd3667;
         5'd11:   r = 22'd1833;
         5'd12:   r = 22'd917;
         5'd13:   r = 22'd458;
         5'd14:   r = 22'd229;
         5'd15:   r = 22'd115;
         5'd16:   r = 22'd57;
         5'd17:   r = 22'd29;
         5'd18:   r = 22'd14;
         5'd19:   r = 22'd7;
         default: r = 22'd0;
      endcase
      return r;
   endfunction

endpackage

@@ sv/sbd_cell.sv @@
// ----------------------------------------------------------------------------
// sbd_cell
// one link of the chain: one cordic vectoring step and, in the first cells,
// one bit of the distance search
// ----------------------------------------------------------------------------
module sbd_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       en,
   input  logic [sbd_pkg::STEP_W-1:0] step,
   input  logic [31:0]                radius_sq,
   input  logic                       in_valid,
   input  sbd_pkg::cell_type          in_word,
   output logic                       out_valid,
   output sbd_pkg::cell_type          out_word
);

   logic              valid_ff;
   sbd_pkg::cell_type word_ff;
   sbd_pkg::cell_type word_in;
   logic signed [32:0] xs;
   logic signed [32:0] ys;
   logic [2:0]         k;
   logic [15:0]        cand2;
   logic [47:0]        prod;

   always_comb begin
      word_in = in_word;
      xs      = $signed(in_word.x) >>> step;
      ys      = $signed(in_word.y) >>> step;
      if (!in_word.y[32] && (in_word.y != '0)) begin
         word_in.x = in_word.x + ys;
         word_in.y = in_word.y - xs;
         word_in.z = in_word.z + $signed({3'b000, sbd_pkg::atan_deg(step)});
      end else begin
         word_in.x = in_word.x - ys;
         word_in.y = in_word.y + xs;
         word_in.z = in_word.z - $signed({3'b000, sbd_pkg::atan_deg(step)});
      end
      k     = 3'(sbd_pkg::DIST_BITS - 1) - step[2:0];
      cand2 = in_word.d2 + (16'(in_word.d) << (k + 3'd1)) + (16'd1 << {k, 1'b0});
      prod  = 48'(cand2) * 48'(radius_sq);
      if ((32'(step) < sbd_pkg::DIST_BITS) && ({2'b00, prod} <= in_word.target)) begin
         word_in.d  = in_word.d | (8'd1 << k);
         word_in.d2 = cand2;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         word_ff <= word_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_word  = word_ff;

endmodule

@@ sv/source_bearing_and_distance.sv @@
// ----------------------------------------------------------------------------
// source_bearing_and_distance
// bearing and scaled distance of a sound source seen from the listener
// ----------------------------------------------------------------------------
// Takes one word per cycle while req_ready is high and returns one word for
// each, in order, when the result side is ready, after three setup stages,
// the 20-cell cordic chain and the output register; a skid register behind
// the output lets one more result land while a word waits.
// The audible radius register takes effect on the cycle after the write.
module source_bearing_and_distance (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sbd_pkg::req_word_type req_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sbd_pkg::rsp_word_type rsp_word,
   input  logic                  csr_write_en,
   input  logic [15:0]           csr_write_data
);

   localparam int N = sbd_pkg::CORDIC_STEPS;

   typedef struct packed {
      logic [3:0]          channel;
      sbd_pkg::action_type action;
      logic signed [16:0]  a;
      logic signed [16:0]  b;
   } s1_type;

   typedef struct packed {
      logic [3:0]          channel;
      sbd_pkg::action_type action;
      logic [31:0]         sq_a;
      logic [31:0]         sq_b;
      logic [8:0]          base;
      logic                use_cordic;
      logic [15:0]         num;
      logic [15:0]         den;
   } s2_type;

   logic [31:0] radius_sq_ff;
   logic [31:0] radius_sq_in;
   logic [15:0] radius_new;

   logic   en;
   logic   s1_v_ff, s2_v_ff, hd_v_ff;
   s1_type s1_ff, s1_in;
   s2_type s2_ff, s2_in;
   sbd_pkg::cell_type hd_ff, hd_in;
   logic [15:0] mag_a, mag_b;
   logic [33:0] sum_sq;

   logic              chain_v [0:N];
   sbd_pkg::cell_type chain_w [0:N];

   sbd_pkg::rsp_word_type fin_word;
   logic signed [24:0]    zc;
   logic [6:0]            deg;
   logic                  out_v_ff, skid_v_ff;
   sbd_pkg::rsp_word_type out_ff, skid_ff;
   logic                  inc_v, out_free;

   // audible radius kept as its square
   always_comb begin
      radius_new   = (csr_write_data == 16'd0) ? 16'd1 : csr_write_data;
      radius_sq_in = 32'(radius_new) * 32'(radius_new);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_sq_ff <= 32'd1;
      end else if (csr_write_en) begin
         radius_sq_ff <= radius_sq_in;
      end
   end

   assign en        = !skid_v_ff;
   assign req_ready = en;

   // stage 1: offsets and action
   always_comb begin
      s1_in.channel = req_word.channel;
      s1_in.a = 17'(req_word.source_x) - 17'(req_word.listener_x);
      s1_in.b = 17'(req_word.listener_y) - 17'(req_word.source_y);
      if (req_word.slot_active && req_word.spatial_enabled &&
          (32'(req_word.channel) < sbd_pkg::CHANNELS)) begin
         s1_in.action = req_word.playing ? sbd_pkg::ACT_POS : sbd_pkg::ACT_STOP;
      end else begin
         s1_in.action = sbd_pkg::ACT_NONE;
      end
   end

   // stage 2: squares and quadrant
   always_comb begin
      mag_a = s1_ff.a[16] ? 16'(-s1_ff.a) : s1_ff.a[15:0];
      mag_b = s1_ff.b[16] ? 16'(-s1_ff.b) : s1_ff.b[15:0];
      s2_in.channel    = s1_ff.channel;
      s2_in.action     = s1_ff.action;
      s2_in.sq_a       = 32'(s1_ff.a * s1_ff.a);
      s2_in.sq_b       = 32'(s1_ff.b * s1_ff.b);
      s2_in.use_cordic = 1'b0;
      s2_in.num        = mag_a;
      s2_in.den        = mag_b;
      s2_in.base       = 9'd0;
      if (s1_ff.action != sbd_pkg::ACT_POS) begin
         s2_in.base = 9'd0;
      end else if (s1_ff.a == '0) begin
         s2_in.base = s1_ff.b[16] ? 9'd180 : 9'd0;
      end else if (s1_ff.b == '0) begin
         s2_in.base = s1_ff.a[16] ? 9'd270 : 9'd90;
      end else begin
         s2_in.use_cordic = 1'b1;
         case ({s1_ff.a[16], s1_ff.b[16]})
            2'b00: begin
               s2_in.base = 9'd0;
            end
            2'b01: begin
               s2_in.base = 9'd90;
               s2_in.num  = mag_b;
               s2_in.den  = mag_a;
            end
            2'b11: begin
               s2_in.base = 9'd180;
            end
            default: begin
               s2_in.base = 9'd270;
               s2_in.num  = mag_b;
               s2_in.den  = mag_a;
            end
         endcase
      end
   end

   // chain head: target 65025 * s and prescaled vector
   always_comb begin
      sum_sq           = 34'(s2_ff.sq_a) + 34'(s2_ff.sq_b);
      hd_in.channel    = s2_ff.channel;
      hd_in.action     = s2_ff.action;
      hd_in.base       = s2_ff.base;
      hd_in.use_cordic = s2_ff.use_cordic;
      hd_in.x          = $signed({3'b000, s2_ff.den, 14'd0});
      hd_in.y          = $signed({3'b000, s2_ff.num, 14'd0});
      hd_in.z          = '0;
      hd_in.target     = (50'(sum_sq) << 16) - (50'(sum_sq) << 9) + 50'(sum_sq);
      hd_in.d          = '0;
      hd_in.d2         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         hd_v_ff <= 1'b0;
      end else if (en) begin
         s1_v_ff <= req_valid;
         s2_v_ff <= s1_v_ff;
         hd_v_ff <= s2_v_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         hd_ff <= hd_in;
      end
   end

   assign chain_v[0] = hd_v_ff;
   assign chain_w[0] = hd_ff;

   for (genvar i = 1; i <= N; i++) begin : g_cell
      sbd_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .step      (sbd_pkg::STEP_W'(i - 1)),
         .radius_sq (radius_sq_ff),
         .in_valid  (chain_v[i-1]),
         .in_word   (chain_w[i-1]),
         .out_valid (chain_v[i]),
         .out_word  (chain_w[i])
      );
   end

   // final angle clamp and assembly
   always_comb begin
      if (chain_w[N].z[24]) begin
         zc = '0;
      end else if (chain_w[N].z > 25'(sbd_pkg::QUARTER_Q16 - 1)) begin
         zc = 25'(sbd_pkg::QUARTER_Q16 - 1);
      end else begin
         zc = chain_w[N].z;
      end
      deg                  = zc[22:16];
      fin_word.out_channel = chain_w[N].channel;
      fin_word.action      = chain_w[N].action;
      if (chain_w[N].action == sbd_pkg::ACT_POS) begin
         fin_word.bearing_deg     = chain_w[N].base +
                                    (chain_w[N].use_cordic ? 9'(deg) : 9'd0);
         fin_word.scaled_distance = chain_w[N].d;
      end else begin
         fin_word.bearing_deg     = 9'd0;
         fin_word.scaled_distance = 8'd0;
      end
   end

   // output register with skid
   assign inc_v    = chain_v[N] && en;
   assign out_free = !out_v_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (out_free) begin
         out_v_ff  <= skid_v_ff || inc_v;
         skid_v_ff <= 1'b0;
      end else if (inc_v) begin
         skid_v_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (out_free) begin
         out_ff <= skid_v_ff ? skid_ff : fin_word;
      end else if (inc_v) begin
         skid_ff <= fin_word;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_word  = out_ff;

endmodule

@@ sv/sbd_checker.sv @@
// ----------------------------------------------------------------------------
// sbd_port_checks
// port-level checks for the bearing/distance block
// ----------------------------------------------------------------------------
module sbd_port_checks (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_valid,
   input logic                  req_ready,
   input sbd_pkg::req_word_type req_word,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input sbd_pkg::rsp_word_type rsp_word,
   input logic                  csr_write_en,
   input logic [15:0]           csr_write_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word))
      else $error("result word dropped or changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_unused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_word.action != sbd_pkg::ACT_POS) |->
         (rsp_word.bearing_deg == 9'd0) && (rsp_word.scaled_distance == 8'd0))
      else $error("bearing or distance set without a pan command");

   a_bearing_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_word.bearing_deg <= 9'd359))
      else $error("bearing out of range");

endmodule

bind source_bearing_and_distance sbd_port_checks u_sbd_port_checks (.*);
